[rtl/mdh_pkg.sv]
// Shared types, opcode constants and result codes for the MIPS decode and hazard stall unit.
`default_nettype none

package mdh_pkg;

	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_BLT   = 6'h01;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_JAL   = 6'h03;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_BNE   = 6'h05;
	localparam logic [5:0] OPC_BGT   = 6'h07;
	localparam logic [5:0] OPC_ADDI  = 6'h08;
	localparam logic [5:0] OPC_ADDIU = 6'h09;
	localparam logic [5:0] OPC_SLTI  = 6'h0A;
	localparam logic [5:0] OPC_ANDI  = 6'h0C;
	localparam logic [5:0] OPC_LI    = 6'h0E;
	localparam logic [5:0] OPC_LUI   = 6'h0F;
	localparam logic [5:0] OPC_PRINT = 6'h10;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2B;
	localparam logic [5:0] OPC_END   = 6'h3F;

	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_DIV  = 6'h1A;

	typedef enum logic [4:0] {
		CLS_NONE   = 5'd0,
		CLS_ADD    = 5'd1,
		CLS_SUB    = 5'd2,
		CLS_MULT   = 5'd3,
		CLS_DIV    = 5'd4,
		CLS_J      = 5'd5,
		CLS_JAL    = 5'd6,
		CLS_BEQ    = 5'd7,
		CLS_BNE    = 5'd8,
		CLS_ADDI   = 5'd9,
		CLS_ADDIU  = 5'd10,
		CLS_LUI    = 5'd11,
		CLS_ANDI   = 5'd12,
		CLS_SLTI   = 5'd13,
		CLS_LW     = 5'd14,
		CLS_SW     = 5'd15,
		CLS_LI     = 5'd16,
		CLS_PRINT  = 5'd17,
		CLS_END    = 5'd18,
		CLS_BGT    = 5'd19,
		CLS_BLT    = 5'd20,
		CLS_BUBBLE = 5'd21
	} op_class_t;

	typedef logic [4:0] reg_idx_t;

	typedef struct packed {
		op_class_t        op_class;
		reg_idx_t         src_reg;
		reg_idx_t         tgt_reg;
		reg_idx_t         dst_reg;
		logic signed [26:0] imm_value;
		logic             reads_src;
		logic             reads_tgt;
		logic             writes_dest;
		reg_idx_t         dest_idx;
	} dec_info_t;

endpackage

`default_nettype wire

[rtl/mdh_if.sv]
// Valid/ready channel interfaces for instruction requests and decoded results.
`default_nettype none

interface mdh_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;

	modport source (output valid, output instr_word, input ready);
	modport sink (input valid, input instr_word, output ready);
endinterface

interface mdh_result_if;
	logic               valid;
	logic               ready;
	logic [4:0]         op_class;
	logic [4:0]         src_reg;
	logic [4:0]         tgt_reg;
	logic [4:0]         dst_reg;
	logic signed [26:0] imm_value;
	logic               stall_res;

	modport source (output valid, output op_class, output src_reg, output tgt_reg,
		output dst_reg, output imm_value, output stall_res, input ready);
	modport sink (input valid, input op_class, input src_reg, input tgt_reg,
		input dst_reg, input imm_value, input stall_res, output ready);
endinterface

`default_nettype wire

[rtl/mdh_decode.sv]
// Combinational instruction classifier and field extractor.
`default_nettype none

module mdh_decode (
	input  wire logic [31:0]        instr_word,
	output mdh_pkg::dec_info_t      dec
);

	logic [5:0]           opc;
	logic [5:0]           fn;
	mdh_pkg::op_class_t   cls;
	logic signed [26:0]   sext_imm;
	logic                 is_arith;
	logic                 is_itype;

	assign opc      = instr_word[31:26];
	assign fn       = instr_word[5:0];
	assign sext_imm = {{11{instr_word[15]}}, instr_word[15:0]};

	always_comb begin
		case (opc)
			mdh_pkg::OPC_RTYPE: begin
				case (fn)
					mdh_pkg::FN_ADD:  cls = mdh_pkg::CLS_ADD;
					mdh_pkg::FN_SUB:  cls = mdh_pkg::CLS_SUB;
					mdh_pkg::FN_MULT: cls = mdh_pkg::CLS_MULT;
					mdh_pkg::FN_DIV:  cls = mdh_pkg::CLS_DIV;
					default:          cls = mdh_pkg::CLS_NONE;
				endcase
			end
			mdh_pkg::OPC_J:     cls = mdh_pkg::CLS_J;
			mdh_pkg::OPC_JAL:   cls = mdh_pkg::CLS_JAL;
			mdh_pkg::OPC_BEQ:   cls = mdh_pkg::CLS_BEQ;
			mdh_pkg::OPC_BNE:   cls = mdh_pkg::CLS_BNE;
			mdh_pkg::OPC_ADDI:  cls = mdh_pkg::CLS_ADDI;
			mdh_pkg::OPC_ADDIU: cls = mdh_pkg::CLS_ADDIU;
			mdh_pkg::OPC_LUI:   cls = mdh_pkg::CLS_LUI;
			mdh_pkg::OPC_ANDI:  cls = mdh_pkg::CLS_ANDI;
			mdh_pkg::OPC_SLTI:  cls = mdh_pkg::CLS_SLTI;
			mdh_pkg::OPC_LW:    cls = mdh_pkg::CLS_LW;
			mdh_pkg::OPC_SW:    cls = mdh_pkg::CLS_SW;
			mdh_pkg::OPC_LI:    cls = mdh_pkg::CLS_LI;
			mdh_pkg::OPC_PRINT: cls = mdh_pkg::CLS_PRINT;
			mdh_pkg::OPC_END:   cls = mdh_pkg::CLS_END;
			mdh_pkg::OPC_BGT:   cls = mdh_pkg::CLS_BGT;
			mdh_pkg::OPC_BLT:   cls = mdh_pkg::CLS_BLT;
			default:            cls = mdh_pkg::CLS_NONE;
		endcase
	end

	assign is_arith = cls inside {mdh_pkg::CLS_ADD, mdh_pkg::CLS_SUB,
		mdh_pkg::CLS_MULT, mdh_pkg::CLS_DIV};
	assign is_itype = cls inside {mdh_pkg::CLS_ADDI, mdh_pkg::CLS_ADDIU,
		mdh_pkg::CLS_LI, mdh_pkg::CLS_LW, mdh_pkg::CLS_SW, mdh_pkg::CLS_BEQ,
		mdh_pkg::CLS_BNE, mdh_pkg::CLS_BGT, mdh_pkg::CLS_BLT, mdh_pkg::CLS_SLTI,
		mdh_pkg::CLS_LUI};

	always_comb begin
		dec           = '0;
		dec.op_class  = cls;
		if (is_arith) begin
			dec.src_reg = instr_word[25:21];
			dec.tgt_reg = instr_word[20:16];
			dec.dst_reg = instr_word[15:11];
		end else if (is_itype) begin
			dec.src_reg   = instr_word[25:21];
			dec.tgt_reg   = instr_word[20:16];
			dec.imm_value = sext_imm;
		end else if (cls == mdh_pkg::CLS_J) begin
			dec.imm_value = {1'b0, instr_word[25:0]};
		end else if (cls == mdh_pkg::CLS_PRINT) begin
			dec.tgt_reg   = instr_word[20:16];
			dec.imm_value = sext_imm;
		end

		// Arithmetic ops, branches and stores read both sources; addi, addiu, lw and slti read rs only; print reads rt.
		if (is_arith || (cls inside {mdh_pkg::CLS_BEQ, mdh_pkg::CLS_BNE,
				mdh_pkg::CLS_BGT, mdh_pkg::CLS_BLT, mdh_pkg::CLS_SW})) begin
			dec.reads_src = 1'b1;
			dec.reads_tgt = 1'b1;
		end else if (cls inside {mdh_pkg::CLS_ADDI, mdh_pkg::CLS_ADDIU,
				mdh_pkg::CLS_LW, mdh_pkg::CLS_SLTI}) begin
			dec.reads_src = 1'b1;
		end else if (cls == mdh_pkg::CLS_PRINT) begin
			dec.reads_tgt = 1'b1;
		end

		if (is_arith) begin
			dec.writes_dest = 1'b1;
			dec.dest_idx    = instr_word[15:11];
		end else if (cls inside {mdh_pkg::CLS_ADDI, mdh_pkg::CLS_ADDIU,
				mdh_pkg::CLS_LW, mdh_pkg::CLS_LI, mdh_pkg::CLS_LUI,
				mdh_pkg::CLS_SLTI}) begin
			dec.writes_dest = 1'b1;
			dec.dest_idx    = instr_word[20:16];
		end
	end

endmodule

`default_nettype wire

[rtl/mdh_hazard.sv]
// Destination history of the two previous instructions and read-after-write hazard check.
`default_nettype none

module mdh_hazard (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mdh_pkg::dec_info_t dec,
	input  wire logic               advance,
	output logic                    stall
);

	logic [1:0]             hist_valid_q;
	mdh_pkg::reg_idx_t      hist_idx_q [2];
	logic [1:0]             hit_src;
	logic [1:0]             hit_tgt;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			hit_src[k] = hist_valid_q[k] && (hist_idx_q[k] != '0) &&
				(hist_idx_q[k] == dec.src_reg);
			hit_tgt[k] = hist_valid_q[k] && (hist_idx_q[k] != '0) &&
				(hist_idx_q[k] == dec.tgt_reg);
		end
	end

	assign stall = (dec.reads_src && (|hit_src)) || (dec.reads_tgt && (|hit_tgt));

	// A bubble enters the history with no destination.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q  <= '0;
			hist_idx_q[0] <= '0;
			hist_idx_q[1] <= '0;
		end else if (advance) begin
			hist_valid_q  <= {hist_valid_q[0], dec.writes_dest && !stall};
			hist_idx_q[1] <= hist_idx_q[0];
			hist_idx_q[0] <= dec.dest_idx;
		end
	end

endmodule

`default_nettype wire

[rtl/mips_decode_with_raw_hazard_stall_unit.sv]
// Top level of the MIPS decode stage with read-after-write hazard stall.
// A request is registered in the input register on acceptance, and its result is
// registered in the output register when the input register advances.
// Throughput: one request per cycle while results are taken by the receiver.
// Reset: arst_n clears the pipeline valid flags and the destination history at once.
`default_nettype none

module mips_decode_with_raw_hazard_stall_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mdh_instr_if.sink        instr,
	mdh_result_if.source     result
);

	logic               valid_s1;
	logic [31:0]        instr_s1;
	logic               out_valid_q;
	mdh_pkg::dec_info_t dec;
	logic               stall;
	logic               advance;

	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			instr_s1 <= instr.instr_word;
		end
	end

	mdh_decode u_decode (
		.instr_word (instr_s1),
		.dec        (dec)
	);

	mdh_hazard u_hazard (
		.clk     (clk),
		.arst_n  (arst_n),
		.dec     (dec),
		.advance (advance),
		.stall   (stall)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (stall) begin
				result.op_class  <= mdh_pkg::CLS_BUBBLE;
				result.src_reg   <= '0;
				result.tgt_reg   <= '0;
				result.dst_reg   <= '0;
				result.imm_value <= '0;
				result.stall_res <= 1'b1;
			end else begin
				result.op_class  <= dec.op_class;
				result.src_reg   <= dec.src_reg;
				result.tgt_reg   <= dec.tgt_reg;
				result.dst_reg   <= dec.dst_reg;
				result.imm_value <= dec.imm_value;
				result.stall_res <= 1'b0;
			end
		end
	end

	assign result.valid = out_valid_q;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the MIPS decode stage with read-after-write hazard stall.
`timescale 1ns / 1ps

module tb_top;

	localparam int RANDOM_WORDS = 1900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MID_DRAIN_AT = 1000;
	localparam int QUIET_TAIL = 150;

	typedef struct packed {
		mdh_pkg::op_class_t cls;
		logic [4:0]  src;
		logic [4:0]  tgt;
		logic [4:0]  dst;
		logic [26:0] imm;
		logic        stall;
	} decode_t;

	logic clk;
	logic arst_n;

	mdh_instr_if  instr_ch ();
	mdh_result_if result_ch ();

	mips_decode_with_raw_hazard_stall_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	logic [31:0] pending_words[$];
	decode_t     expected_decodes[$];
	logic        dest_live[2];
	logic [4:0]  dest_idx[2];

	int  issued_cnt;
	int  accepted_cnt;
	int  decoded_cnt;
	int  stall_cnt;
	int  err_cnt;
	int  cycle_cnt;
	int  directed_n;
	int  send_idle;
	int  recv_idle;
	bit  cls_seen[0:31];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void add_word(logic [31:0] w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic void add_expected(decode_t d);
		expected_decodes.insert(expected_decodes.size(), d);
	endfunction

	function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
		logic [5:0] fn);
		return {mdh_pkg::OPC_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] i_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {opc, rs, rt, imm};
	endfunction

	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 3) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, 3));
	endfunction

	// Mostly well-formed instructions over a few registers, so that hazards are frequent.
	function automatic logic [31:0] rand_word();
		logic [31:0] rv;
		logic [5:0]  opc;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		int          pick;
		rv = $urandom;
		if ($urandom_range(0, 9) == 0)
			return rv;
		rs = pick_reg();
		rt = pick_reg();
		rd = pick_reg();
		pick = $urandom_range(0, 19);
		opc = mdh_pkg::OPC_RTYPE;
		fn = mdh_pkg::FN_ADD;
		case (pick)
			0: fn = mdh_pkg::FN_ADD;
			1: fn = mdh_pkg::FN_SUB;
			2: fn = mdh_pkg::FN_MULT;
			3: fn = mdh_pkg::FN_DIV;
			4: opc = mdh_pkg::OPC_J;
			5: opc = mdh_pkg::OPC_JAL;
			6: opc = mdh_pkg::OPC_BEQ;
			7: opc = mdh_pkg::OPC_BNE;
			8: opc = mdh_pkg::OPC_ADDI;
			9: opc = mdh_pkg::OPC_ADDIU;
			10: opc = mdh_pkg::OPC_LUI;
			11: opc = mdh_pkg::OPC_ANDI;
			12: opc = mdh_pkg::OPC_SLTI;
			13: opc = mdh_pkg::OPC_LW;
			14: opc = mdh_pkg::OPC_SW;
			15: opc = mdh_pkg::OPC_LI;
			16: opc = mdh_pkg::OPC_PRINT;
			17: opc = mdh_pkg::OPC_END;
			18: opc = mdh_pkg::OPC_BGT;
			default: opc = mdh_pkg::OPC_BLT;
		endcase
		if (pick < 4)
			return {mdh_pkg::OPC_RTYPE, rs, rt, rd, rv[10:6], fn};
		return {opc, rs, rt, rv[15:0]};
	endfunction

	function automatic logic live_dest(logic [4:0] r);
		return (dest_live[0] && dest_idx[0] != 5'd0 && dest_idx[0] == r) ||
			(dest_live[1] && dest_idx[1] != 5'd0 && dest_idx[1] == r);
	endfunction

	function automatic decode_t decode_and_track(logic [31:0] w);
		decode_t    d;
		logic       hz;
		logic       nv;
		logic [4:0] ni;
		d = '0;
		hz = 1'b0;
		nv = 1'b0;
		ni = 5'd0;
		case (w[31:26])
			mdh_pkg::OPC_RTYPE: begin
				case (w[5:0])
					mdh_pkg::FN_ADD: d.cls = mdh_pkg::CLS_ADD;
					mdh_pkg::FN_SUB: d.cls = mdh_pkg::CLS_SUB;
					mdh_pkg::FN_MULT: d.cls = mdh_pkg::CLS_MULT;
					mdh_pkg::FN_DIV: d.cls = mdh_pkg::CLS_DIV;
					default: d.cls = mdh_pkg::CLS_NONE;
				endcase
			end
			mdh_pkg::OPC_J: d.cls = mdh_pkg::CLS_J;
			mdh_pkg::OPC_JAL: d.cls = mdh_pkg::CLS_JAL;
			mdh_pkg::OPC_BEQ: d.cls = mdh_pkg::CLS_BEQ;
			mdh_pkg::OPC_BNE: d.cls = mdh_pkg::CLS_BNE;
			mdh_pkg::OPC_ADDI: d.cls = mdh_pkg::CLS_ADDI;
			mdh_pkg::OPC_ADDIU: d.cls = mdh_pkg::CLS_ADDIU;
			mdh_pkg::OPC_LUI: d.cls = mdh_pkg::CLS_LUI;
			mdh_pkg::OPC_ANDI: d.cls = mdh_pkg::CLS_ANDI;
			mdh_pkg::OPC_SLTI: d.cls = mdh_pkg::CLS_SLTI;
			mdh_pkg::OPC_LW: d.cls = mdh_pkg::CLS_LW;
			mdh_pkg::OPC_SW: d.cls = mdh_pkg::CLS_SW;
			mdh_pkg::OPC_LI: d.cls = mdh_pkg::CLS_LI;
			mdh_pkg::OPC_PRINT: d.cls = mdh_pkg::CLS_PRINT;
			mdh_pkg::OPC_END: d.cls = mdh_pkg::CLS_END;
			mdh_pkg::OPC_BGT: d.cls = mdh_pkg::CLS_BGT;
			mdh_pkg::OPC_BLT: d.cls = mdh_pkg::CLS_BLT;
			default: d.cls = mdh_pkg::CLS_NONE;
		endcase

		if (d.cls inside {mdh_pkg::CLS_ADD, mdh_pkg::CLS_SUB, mdh_pkg::CLS_MULT,
			mdh_pkg::CLS_DIV}) begin
			d.src = w[25:21];
			d.tgt = w[20:16];
			d.dst = w[15:11];
		end else if (d.cls inside {mdh_pkg::CLS_ADDI, mdh_pkg::CLS_ADDIU, mdh_pkg::CLS_LI,
			mdh_pkg::CLS_LW, mdh_pkg::CLS_SW, mdh_pkg::CLS_BEQ, mdh_pkg::CLS_BNE,
			mdh_pkg::CLS_BGT, mdh_pkg::CLS_BLT, mdh_pkg::CLS_SLTI, mdh_pkg::CLS_LUI}) begin
			d.src = w[25:21];
			d.tgt = w[20:16];
			d.imm = {{11{w[15]}}, w[15:0]};
		end else if (d.cls == mdh_pkg::CLS_J) begin
			d.imm = {1'b0, w[25:0]};
		end else if (d.cls == mdh_pkg::CLS_PRINT) begin
			d.tgt = w[20:16];
			d.imm = {{11{w[15]}}, w[15:0]};
		end

		if (d.cls inside {mdh_pkg::CLS_ADD, mdh_pkg::CLS_SUB, mdh_pkg::CLS_MULT,
			mdh_pkg::CLS_DIV, mdh_pkg::CLS_BEQ, mdh_pkg::CLS_BNE, mdh_pkg::CLS_BGT,
			mdh_pkg::CLS_BLT, mdh_pkg::CLS_SW})
			hz = live_dest(d.src) || live_dest(d.tgt);
		else if (d.cls inside {mdh_pkg::CLS_ADDI, mdh_pkg::CLS_ADDIU, mdh_pkg::CLS_LW,
			mdh_pkg::CLS_SLTI})
			hz = live_dest(d.src);
		else if (d.cls == mdh_pkg::CLS_PRINT)
			hz = live_dest(d.tgt);

		if (hz) begin
			d = '0;
			d.cls = mdh_pkg::CLS_BUBBLE;
			d.stall = 1'b1;
		end else if (d.cls inside {mdh_pkg::CLS_ADD, mdh_pkg::CLS_SUB, mdh_pkg::CLS_MULT,
			mdh_pkg::CLS_DIV}) begin
			nv = 1'b1;
			ni = d.dst;
		end else if (d.cls inside {mdh_pkg::CLS_ADDI, mdh_pkg::CLS_ADDIU, mdh_pkg::CLS_LW,
			mdh_pkg::CLS_LI, mdh_pkg::CLS_LUI, mdh_pkg::CLS_SLTI}) begin
			nv = 1'b1;
			ni = d.tgt;
		end

		dest_live[1] = dest_live[0];
		dest_idx[1] = dest_idx[0];
		dest_live[0] = nv;
		dest_idx[0] = ni;
		return d;
	endfunction

	task automatic report(string field, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
			err_cnt++;
		end
	endtask

	function automatic logic may_idle();
		return pending_words.size() > QUIET_TAIL && ((issued_cnt / 256) % 4) != 3;
	endfunction

	// Instruction sender.
	always @(negedge clk) begin : sender
		logic        nv;
		logic [31:0] nw;
		nv = instr_ch.valid;
		nw = instr_ch.instr_word;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (issued_cnt == accepted_cnt) begin
			nv = 1'b0;
			if (send_idle > 0) begin
				send_idle--;
			end else if (pending_words.size() > 0) begin
				if ((issued_cnt == directed_n || issued_cnt == MID_DRAIN_AT) &&
					expected_decodes.size() != 0) begin
					nv = 1'b0;
				end else if (may_idle() && $urandom_range(0, 7) == 0) begin
					send_idle = $urandom_range(0, 3);
				end else begin
					nw = pending_words.pop_front();
					nv = 1'b1;
					issued_cnt++;
				end
			end
		end
		instr_ch.valid <= nv;
		instr_ch.instr_word <= nw;
	end

	// Result receiver backpressure.
	always @(negedge clk) begin : receiver
		logic r;
		if (recv_idle > 0) begin
			recv_idle--;
			r = 1'b0;
		end else if (may_idle() && $urandom_range(0, 7) == 0) begin
			recv_idle = $urandom_range(0, 3);
			r = 1'b0;
		end else begin
			r = 1'b1;
		end
		result_ch.ready <= r;
	end

	// Request and result monitor.
	always @(posedge clk) begin : monitor
		decode_t e;
		cycle_cnt++;
		if (instr_ch.valid && instr_ch.ready) begin
			add_expected(decode_and_track(instr_ch.instr_word));
			accepted_cnt++;
		end
		if (result_ch.valid && result_ch.ready) begin
			if (expected_decodes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got class %0d", $time,
					result_ch.op_class);
				err_cnt++;
			end else begin
				e = expected_decodes.pop_front();
				report("op_class", 32'(e.cls), 32'(result_ch.op_class));
				report("src_reg", 32'(e.src), 32'(result_ch.src_reg));
				report("tgt_reg", 32'(e.tgt), 32'(result_ch.tgt_reg));
				report("dst_reg", 32'(e.dst), 32'(result_ch.dst_reg));
				report("imm_value", 32'(e.imm), 32'(unsigned'(result_ch.imm_value)));
				report("stall_res", 32'(e.stall), 32'(result_ch.stall_res));
				decoded_cnt++;
				if (e.stall)
					stall_cnt++;
				cls_seen[e.cls] = 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
			expected_decodes.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int n_cls;
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.instr_word = 32'd0;
		result_ch.ready = 1'b0;
		issued_cnt = 0;
		accepted_cnt = 0;
		decoded_cnt = 0;
		stall_cnt = 0;
		err_cnt = 0;
		cycle_cnt = 0;
		send_idle = 0;
		recv_idle = 0;
		n_cls = 0;
		dest_live[0] = 1'b0;
		dest_live[1] = 1'b0;
		dest_idx[0] = 5'd0;
		dest_idx[1] = 5'd0;

		add_word(32'h0000_0000);
		add_word(32'hFFFF_FFFF);
		add_word(r_word(5'd1, 5'd2, 5'd3, mdh_pkg::FN_ADD));
		add_word(r_word(5'd3, 5'd4, 5'd5, mdh_pkg::FN_SUB));
		add_word(r_word(5'd6, 5'd3, 5'd7, mdh_pkg::FN_MULT));
		add_word(i_word(mdh_pkg::OPC_ADDI, 5'd0, 5'd0, 16'h8000));
		add_word(r_word(5'd0, 5'd0, 5'd31, mdh_pkg::FN_DIV));
		add_word(i_word(mdh_pkg::OPC_PRINT, 5'd5, 5'd31, 16'h7FFF));
		add_word({mdh_pkg::OPC_J, 26'h3FF_FFFF});
		add_word({mdh_pkg::OPC_JAL, 26'h3FF_FFFF});
		add_word({mdh_pkg::OPC_ANDI, 26'h3FF_FFFF});
		add_word(i_word(mdh_pkg::OPC_LUI, 5'd31, 5'd10, 16'hFFFF));
		add_word(i_word(mdh_pkg::OPC_SW, 5'd1, 5'd10, 16'h0004));
		add_word(i_word(mdh_pkg::OPC_LI, 5'd2, 5'd11, 16'h0001));
		add_word(i_word(mdh_pkg::OPC_BEQ, 5'd11, 5'd0, 16'hFFFE));
		add_word(i_word(mdh_pkg::OPC_BNE, 5'd12, 5'd13, 16'h8000));
		add_word(i_word(mdh_pkg::OPC_BGT, 5'd31, 5'd31, 16'h7FFF));
		add_word(i_word(mdh_pkg::OPC_BLT, 5'd0, 5'd1, 16'h0000));
		add_word(i_word(mdh_pkg::OPC_ADDIU, 5'd1, 5'd12, 16'h1234));
		add_word(i_word(mdh_pkg::OPC_SLTI, 5'd12, 5'd13, 16'h8001));
		add_word(i_word(mdh_pkg::OPC_LW, 5'd3, 5'd14, 16'h0010));
		add_word({mdh_pkg::OPC_RTYPE, 20'hFFFFF, 6'h3E});
		add_word({6'h3E, 26'h3FF_FFFF});
		add_word(r_word(5'd14, 5'd14, 5'd0, mdh_pkg::FN_ADD));
		directed_n = pending_words.size();
		for (int i = 0; i < RANDOM_WORDS; i++)
			add_word(rand_word());

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || accepted_cnt != issued_cnt)
			@(posedge clk);
		while (expected_decodes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		for (int c = 0; c < 32; c++)
			n_cls += cls_seen[c];
		$display("Decoded %0d instructions; %0d were replaced by a bubble for a hazard.",
			decoded_cnt, stall_cnt);
		$display("%0d distinct result classes appeared under random valid and ready gaps.",
			n_cls);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/mdh_pkg.sv
rtl/mdh_if.sv
rtl/mdh_decode.sv
rtl/mdh_hazard.sv
rtl/mips_decode_with_raw_hazard_stall_unit.sv
tb/tb_top.sv
